[rtl/rt_pkg.sv]
// Shared types, constants and codes for the hashed IPv4 route table.
// No dependencies; used by every rtl file.
`timescale 1ns / 1ps

package rt_pkg;

    localparam int DEF_NUM_ROUTES  = 2048;
    localparam int DEF_NUM_BUCKETS = 256;
    localparam logic [15:0] AGE_RESET = 16'd600;

    localparam int IN_W  = 168;
    localparam int OUT_W = 40;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_ADD    = 2'd1,
        FN_DEL    = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_DEFAULT   = 3'd1,
        ST_UPDATED   = 3'd2,
        ST_INSTALLED = 3'd3,
        ST_FULL      = 3'd4,
        ST_DELETED   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        WM_FIND,
        WM_EVICT,
        WM_INSERT
    } walk_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEADQ,
        S_ENT,
        S_ENTQ,
        S_FREE,
        S_FREEQ,
        S_WSLOT,
        S_LINK,
        S_LINK2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gate;
        logic [7:0]  metric;
        logic [31:0] stamp;
    } route_t;

    typedef struct packed {
        logic route;
        logic gate_metric;
        logic stamp;
        logic link;
    } ent_we_t;

    typedef struct packed {
        logic hit;
        logic same_dest;
        logic same_route;
        logic upd;
        logic stamp_ok;
        logic mask_below;
        logic evict;
    } cmp_t;

endpackage

[rtl/rt_entry_mem.sv]
// Route entry store: route fields, chain links and used flags.
// Depends on rt_pkg.
`timescale 1ns / 1ps

module rt_entry_mem #(
    parameter int NUM_ROUTES = rt_pkg::DEF_NUM_ROUTES,
    parameter int AW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1,
    parameter int LW = $clog2(NUM_ROUTES + 1)
) (
    input  logic              clk,
    input  logic [AW-1:0]     raddr,
    output rt_pkg::route_t    rd_route,
    output logic [LW-1:0]     rd_link,
    input  rt_pkg::ent_we_t   we,
    input  logic [AW-1:0]     waddr,
    input  rt_pkg::route_t    wr_route,
    input  logic [LW-1:0]     wr_link,
    input  logic [AW-1:0]     u_raddr,
    output logic              u_rdata,
    input  logic              u_we,
    input  logic [AW-1:0]     u_waddr,
    input  logic              u_wdata
);

    logic [31:0]   dest_mem   [NUM_ROUTES];
    logic [31:0]   mask_mem   [NUM_ROUTES];
    logic [31:0]   gate_mem   [NUM_ROUTES];
    logic [7:0]    metric_mem [NUM_ROUTES];
    logic [31:0]   stamp_mem  [NUM_ROUTES];
    logic [LW-1:0] link_mem   [NUM_ROUTES];
    logic          used_mem   [NUM_ROUTES];

    always_ff @(posedge clk)
    begin
        if (we.route)
        begin
            dest_mem[waddr] <= wr_route.dest;
            mask_mem[waddr] <= wr_route.mask;
        end
        if (we.route || we.gate_metric)
        begin
            gate_mem[waddr]   <= wr_route.gate;
            metric_mem[waddr] <= wr_route.metric;
        end
        if (we.route || we.stamp)
        begin
            stamp_mem[waddr] <= wr_route.stamp;
        end
        if (we.link)
        begin
            link_mem[waddr] <= wr_link;
        end
        rd_route.dest   <= dest_mem[raddr];
        rd_route.mask   <= mask_mem[raddr];
        rd_route.gate   <= gate_mem[raddr];
        rd_route.metric <= metric_mem[raddr];
        rd_route.stamp  <= stamp_mem[raddr];
        rd_link         <= link_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            used_mem[u_waddr] <= u_wdata;
        end
        u_rdata <= used_mem[u_raddr];
    end

endmodule

[rtl/rt_head_mem.sv]
// Bucket head store: one chain head pointer per hash bucket.
// Depends on rt_pkg.
`timescale 1ns / 1ps

module rt_head_mem #(
    parameter int NUM_BUCKETS = rt_pkg::DEF_NUM_BUCKETS,
    parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
    parameter int LW = 12
) (
    input  logic          clk,
    input  logic [BW-1:0] raddr,
    output logic [LW-1:0] rdata,
    input  logic          we,
    input  logic [BW-1:0] waddr,
    input  logic [LW-1:0] wdata
);

    logic [LW-1:0] head_mem [NUM_BUCKETS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            head_mem[waddr] <= wdata;
        end
        rdata <= head_mem[raddr];
    end

endmodule

[rtl/rt_cmp.sv]
// Shared compare unit: tests one chain entry against the pending transaction.
// Depends on rt_pkg.
`timescale 1ns / 1ps

module rt_cmp (
    input  rt_pkg::route_t ent,
    input  logic [31:0]    addr,
    input  logic [31:0]    mask,
    input  logic [31:0]    hop,
    input  logic [7:0]     cost,
    input  logic [31:0]    now,
    input  logic [15:0]    age_limit,
    output rt_pkg::cmp_t   res
);

    logic [31:0] age;
    logic        stale;

    assign age   = now - ent.stamp;
    assign stale = age > {16'd0, age_limit};

    always_comb
    begin
        res.hit        = (addr & ent.mask) == ent.dest;
        res.same_dest  = ent.dest == addr;
        res.same_route = (ent.dest == addr) && (ent.mask == mask);
        res.upd        = (cost < ent.metric) || stale;
        res.stamp_ok   = res.upd || (ent.gate == hop);
        res.mask_below = ent.mask < mask;
        res.evict      = stale && (ent.metric != 8'd0);
    end

endmodule

[rtl/ip_route_table.sv]
// Hashed IPv4 route table: lookup, add and delete over chained buckets.
// Depends on rt_pkg, rt_entry_mem, rt_head_mem and rt_cmp.
`timescale 1ns / 1ps

// One transaction at a time. After reset a clearing pass over
// max(NUM_ROUTES, NUM_BUCKETS) indices runs before s_tready rises. A transaction
// first hashes the bucket (up to 765/NUM_BUCKETS subtract steps), then visits each
// chain entry in an S_ENT and an S_ENTQ state through the single entry memory read
// port. An add of a new route also scans the used flags, one S_FREE and S_FREEQ per slot,
// up to the first free one, and when none is free walks the chains in bucket order
// for the first eviction candidate; it then walks the target chain again for the sorted insert.

module ip_route_table #(
    parameter int NUM_ROUTES  = rt_pkg::DEF_NUM_ROUTES,
    parameter int NUM_BUCKETS = rt_pkg::DEF_NUM_BUCKETS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [rt_pkg::IN_W-1:0]  s_tdata,  // addr, net_mask, next_hop, cost, default_gate, now
    input  logic [1:0]               s_tuser,  // func
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [rt_pkg::OUT_W-1:0] m_tdata,  // gate_out, status, zero pad
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_data
);

    localparam int AW    = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
    localparam int LW    = $clog2(NUM_ROUTES + 1);
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CLR_N = (NUM_ROUTES > NUM_BUCKETS) ? NUM_ROUTES : NUM_BUCKETS;
    localparam int CW    = $clog2(CLR_N + 1);
    localparam int SW    = 11;
    localparam logic [LW-1:0] NIL = LW'(NUM_ROUTES);

    rt_pkg::state_t state_reg, state_next;
    rt_pkg::walk_t  mode_reg, mode_next;
    logic [1:0]     func_reg, func_next;
    logic [31:0]    addr_reg, addr_next;
    logic [31:0]    mask_reg, mask_next;
    logic [31:0]    hop_reg, hop_next;
    logic [7:0]     cost_reg, cost_next;
    logic [31:0]    defg_reg, defg_next;
    logic [31:0]    now_reg, now_next;
    logic [15:0]    age_reg;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [BW-1:0]  b_reg, b_next;
    logic [BW-1:0]  scan_reg, scan_next;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [LW-1:0]  prev_reg, prev_next;
    logic [AW-1:0]  slot_reg, slot_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [31:0]    gout_reg, gout_next;
    logic [2:0]     status_reg, status_next;
    logic           mvalid_reg, mvalid_next;
    logic [34:0]    mdata_reg, mdata_next;

    logic [31:0]    in_addr;
    logic [31:0]    cls_mask;
    logic [31:0]    net;

    logic [BW-1:0]  hd_raddr;
    logic [LW-1:0]  hd_rdata;
    logic           hd_we;
    logic [BW-1:0]  hd_waddr;
    logic [LW-1:0]  hd_wdata;

    logic [AW-1:0]   e_raddr;
    rt_pkg::route_t  e_route;
    logic [LW-1:0]   e_link;
    rt_pkg::ent_we_t e_we;
    logic [AW-1:0]   e_waddr;
    rt_pkg::route_t  e_wroute;
    logic [LW-1:0]   e_wlink;
    logic [AW-1:0]   u_raddr;
    logic            u_rdata;
    logic            u_we;
    logic [AW-1:0]   u_waddr;
    logic            u_wdata;

    rt_pkg::cmp_t    cmp;

    rt_entry_mem #(
        .NUM_ROUTES (NUM_ROUTES),
        .AW         (AW),
        .LW         (LW)
    ) u_entry (
        .clk      (clk),
        .raddr    (e_raddr),
        .rd_route (e_route),
        .rd_link  (e_link),
        .we       (e_we),
        .waddr    (e_waddr),
        .wr_route (e_wroute),
        .wr_link  (e_wlink),
        .u_raddr  (u_raddr),
        .u_rdata  (u_rdata),
        .u_we     (u_we),
        .u_waddr  (u_waddr),
        .u_wdata  (u_wdata)
    );

    rt_head_mem #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BW          (BW),
        .LW          (LW)
    ) u_head (
        .clk   (clk),
        .raddr (hd_raddr),
        .rdata (hd_rdata),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata)
    );

    rt_cmp u_cmp (
        .ent       (e_route),
        .addr      (addr_reg),
        .mask      (mask_reg),
        .hop       (hop_reg),
        .cost      (cost_reg),
        .now       (now_reg),
        .age_limit (age_reg),
        .res       (cmp)
    );

    assign s_tready = (state_reg == rt_pkg::S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'd0, mdata_reg};

    // classful network bytes
    assign in_addr  = s_tdata[31:0];
    always_comb
    begin
        unique case (in_addr[31:30])
            2'b11:   cls_mask = 32'hFFFF_FF00;
            2'b10:   cls_mask = 32'hFFFF_0000;
            default: cls_mask = 32'hFF00_0000;
        endcase
    end
    assign net = in_addr & cls_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rt_pkg::S_CLEAR;
            idx_reg    <= '0;
            mvalid_reg <= 1'b0;
            age_reg    <= rt_pkg::AGE_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we)
            begin
                age_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        func_reg   <= func_next;
        addr_reg   <= addr_next;
        mask_reg   <= mask_next;
        hop_reg    <= hop_next;
        cost_reg   <= cost_next;
        defg_reg   <= defg_next;
        now_reg    <= now_next;
        sum_reg    <= sum_next;
        b_reg      <= b_next;
        scan_reg   <= scan_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        slot_reg   <= slot_next;
        gout_reg   <= gout_next;
        status_reg <= status_next;
        mdata_reg  <= mdata_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        mask_next   = mask_reg;
        hop_next    = hop_reg;
        cost_next   = cost_reg;
        defg_next   = defg_reg;
        now_next    = now_reg;
        sum_next    = sum_reg;
        b_next      = b_reg;
        scan_next   = scan_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        slot_next   = slot_reg;
        idx_next    = idx_reg;
        gout_next   = gout_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        hd_raddr = b_reg;
        hd_we    = 1'b0;
        hd_waddr = b_reg;
        hd_wdata = e_link;
        e_raddr  = cur_reg[AW-1:0];
        e_we     = '0;
        e_waddr  = cur_reg[AW-1:0];
        e_wroute = e_route;
        e_wlink  = e_link;
        u_raddr  = idx_reg[AW-1:0];
        u_we     = 1'b0;
        u_waddr  = idx_reg[AW-1:0];
        u_wdata  = 1'b0;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            rt_pkg::S_CLEAR:
            begin
                u_we     = idx_reg < CW'(NUM_ROUTES);
                hd_we    = idx_reg < CW'(NUM_BUCKETS);
                hd_waddr = idx_reg[BW-1:0];
                hd_wdata = NIL;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(CLR_N - 1))
                begin
                    state_next = rt_pkg::S_IDLE;
                end
            end
            rt_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    addr_next  = s_tdata[31:0];
                    mask_next  = s_tdata[63:32];
                    hop_next   = s_tdata[95:64];
                    cost_next  = s_tdata[103:96];
                    defg_next  = s_tdata[135:104];
                    now_next   = s_tdata[167:136];
                    sum_next   = SW'(net[31:24]) + SW'(net[23:16]) + SW'(net[15:8]);
                    mode_next  = rt_pkg::WM_FIND;
                    state_next = rt_pkg::S_HASH;
                end
            end
            rt_pkg::S_HASH:
            begin
                if (sum_reg >= SW'(NUM_BUCKETS))
                begin
                    sum_next = sum_reg - SW'(NUM_BUCKETS);
                end
                else if (func_reg == rt_pkg::FN_NONE)
                begin
                    gout_next   = '0;
                    status_next = rt_pkg::ST_NOT_FOUND;
                    state_next  = rt_pkg::S_DONE;
                end
                else
                begin
                    b_next     = sum_reg[BW-1:0];
                    hd_raddr   = sum_reg[BW-1:0];
                    state_next = rt_pkg::S_HEADQ;
                end
            end
            rt_pkg::S_HEADQ:
            begin
                cur_next   = hd_rdata;
                prev_next  = NIL;
                state_next = rt_pkg::S_ENT;
            end
            rt_pkg::S_ENT:
            begin
                if (cur_reg < NIL)
                begin
                    state_next = rt_pkg::S_ENTQ;
                end
                else
                begin
                    unique case (mode_reg)
                        rt_pkg::WM_FIND:
                        begin
                            if (func_reg == rt_pkg::FN_LOOKUP)
                            begin
                                gout_next   = defg_reg;
                                status_next = rt_pkg::ST_DEFAULT;
                                state_next  = rt_pkg::S_DONE;
                            end
                            else if (func_reg == rt_pkg::FN_ADD)
                            begin
                                idx_next   = '0;
                                state_next = rt_pkg::S_FREE;
                            end
                            else
                            begin
                                gout_next   = '0;
                                status_next = rt_pkg::ST_NOT_FOUND;
                                state_next  = rt_pkg::S_DONE;
                            end
                        end
                        rt_pkg::WM_EVICT:
                        begin
                            if (scan_reg == BW'(NUM_BUCKETS - 1))
                            begin
                                gout_next   = '0;
                                status_next = rt_pkg::ST_FULL;
                                state_next  = rt_pkg::S_DONE;
                            end
                            else
                            begin
                                scan_next  = scan_reg + 1'b1;
                                hd_raddr   = scan_reg + 1'b1;
                                state_next = rt_pkg::S_HEADQ;
                            end
                        end
                        default:
                        begin
                            state_next = rt_pkg::S_LINK;
                        end
                    endcase
                end
            end
            rt_pkg::S_ENTQ:
            begin
                prev_next  = cur_reg;
                cur_next   = e_link;
                state_next = rt_pkg::S_ENT;
                unique case (mode_reg)
                    rt_pkg::WM_FIND:
                    begin
                        if (func_reg == rt_pkg::FN_LOOKUP && cmp.hit)
                        begin
                            gout_next   = e_route.gate;
                            status_next = rt_pkg::ST_FOUND;
                            state_next  = rt_pkg::S_DONE;
                        end
                        else if (func_reg == rt_pkg::FN_ADD && cmp.same_route)
                        begin
                            e_wroute.gate   = hop_reg;
                            e_wroute.metric = cost_reg;
                            e_wroute.stamp  = now_reg;
                            e_we.gate_metric = cmp.upd;
                            e_we.stamp       = cmp.stamp_ok;
                            gout_next   = '0;
                            status_next = rt_pkg::ST_UPDATED;
                            state_next  = rt_pkg::S_DONE;
                        end
                        else if (func_reg == rt_pkg::FN_DEL && cmp.same_dest)
                        begin
                            if (prev_reg == NIL)
                            begin
                                hd_we = 1'b1;
                            end
                            else
                            begin
                                e_we.link = 1'b1;
                                e_waddr   = prev_reg[AW-1:0];
                            end
                            u_we        = 1'b1;
                            u_waddr     = cur_reg[AW-1:0];
                            gout_next   = '0;
                            status_next = rt_pkg::ST_DELETED;
                            state_next  = rt_pkg::S_DONE;
                        end
                    end
                    rt_pkg::WM_EVICT:
                    begin
                        if (cmp.evict)
                        begin
                            if (prev_reg == NIL)
                            begin
                                hd_we    = 1'b1;
                                hd_waddr = scan_reg;
                            end
                            else
                            begin
                                e_we.link = 1'b1;
                                e_waddr   = prev_reg[AW-1:0];
                            end
                            slot_next  = cur_reg[AW-1:0];
                            state_next = rt_pkg::S_WSLOT;
                        end
                    end
                    default:
                    begin
                        if (cmp.mask_below)
                        begin
                            prev_next  = prev_reg;
                            cur_next   = cur_reg;
                            state_next = rt_pkg::S_LINK;
                        end
                    end
                endcase
            end
            rt_pkg::S_FREE:
            begin
                state_next = rt_pkg::S_FREEQ;
            end
            rt_pkg::S_FREEQ:
            begin
                if (!u_rdata)
                begin
                    slot_next  = idx_reg[AW-1:0];
                    state_next = rt_pkg::S_WSLOT;
                end
                else if (idx_reg == CW'(NUM_ROUTES - 1))
                begin
                    mode_next  = rt_pkg::WM_EVICT;
                    scan_next  = '0;
                    hd_raddr   = '0;
                    state_next = rt_pkg::S_HEADQ;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = rt_pkg::S_FREE;
                end
            end
            rt_pkg::S_WSLOT:
            begin
                e_we.route      = 1'b1;
                e_waddr         = slot_reg;
                e_wroute.dest   = addr_reg;
                e_wroute.mask   = mask_reg;
                e_wroute.gate   = hop_reg;
                e_wroute.metric = cost_reg;
                e_wroute.stamp  = now_reg;
                u_we            = 1'b1;
                u_waddr         = slot_reg;
                u_wdata         = 1'b1;
                mode_next       = rt_pkg::WM_INSERT;
                hd_raddr        = b_reg;
                state_next      = rt_pkg::S_HEADQ;
            end
            rt_pkg::S_LINK:
            begin
                e_we.link = 1'b1;
                e_waddr   = slot_reg;
                e_wlink   = cur_reg;
                if (prev_reg == NIL)
                begin
                    hd_we       = 1'b1;
                    hd_wdata    = LW'(slot_reg);
                    gout_next   = '0;
                    status_next = rt_pkg::ST_INSTALLED;
                    state_next  = rt_pkg::S_DONE;
                end
                else
                begin
                    state_next = rt_pkg::S_LINK2;
                end
            end
            rt_pkg::S_LINK2:
            begin
                e_we.link   = 1'b1;
                e_waddr     = prev_reg[AW-1:0];
                e_wlink     = LW'(slot_reg);
                gout_next   = '0;
                status_next = rt_pkg::ST_INSTALLED;
                state_next  = rt_pkg::S_DONE;
            end
            rt_pkg::S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {status_reg, gout_reg};
                    state_next  = rt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rt_pkg::S_IDLE;
            end
        endcase
    end

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rt_pkg::S_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == rt_pkg::S_HASH))
        else $error("accepted transaction did not start hashing");

    a_walk_not_nil: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rt_pkg::S_ENTQ) |-> (cur_reg < NIL))
        else $error("chain walk read a null link");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:32] != 3'd7))
        else $error("undefined status code");

endmodule

[tb/sv/tb_ip_route_table.sv]
// Self-checking testbench for ip_route_table: lookups, adds and deletes
// against a behavioural route table model. Depends on rt_pkg and the rtl.
`timescale 1ns / 1ps

module tb_ip_route_table;

    localparam int NR = rt_pkg::DEF_NUM_ROUTES;
    localparam int NB = rt_pkg::DEF_NUM_BUCKETS;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [rt_pkg::IN_W-1:0]  s_tdata;
    logic [1:0]               s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [rt_pkg::OUT_W-1:0] m_tdata;
    logic                     cfg_we;
    logic [15:0]              cfg_data;

    ip_route_table #(.NUM_ROUTES(NR), .NUM_BUCKETS(NB)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [31:0]     gate;
        rt_pkg::status_t status;
    } route_reply_t;

    // table copy
    logic [31:0] rt_dest  [NR];
    logic [31:0] rt_mask  [NR];
    logic [31:0] rt_gate  [NR];
    logic [7:0]  rt_metric[NR];
    logic [31:0] rt_stamp [NR];
    bit          rt_used  [NR];
    int          rt_next  [NR];
    int          chain_head[NB];
    logic [15:0] max_age;

    route_reply_t replies_due[$];
    int  errors;
    int  sent_cnt;
    int  rx_cnt;
    int  full_cnt;
    int  evict_cnt;
    bit  burst_on;
    int  burst_left;
    int  stall_phase;

    // pool of destinations so adds, lookups and deletes collide often
    logic [31:0] dest_pool[16];
    logic [31:0] mask_pool[8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int bucket_for(logic [31:0] a);
        logic [31:0] cm;
        logic [31:0] n;
        cm = (a[31:30] == 2'b11) ? 32'hFFFFFF00 :
             (a[31:30] == 2'b10) ? 32'hFFFF0000 : 32'hFF000000;
        n = a & cm;
        return (int'(n[31:24]) + int'(n[23:16]) + int'(n[15:8])) % NB;
    endfunction

    function automatic bit aged_out(int i, logic [31:0] t);
        logic [31:0] d;
        d = t - rt_stamp[i];
        return d > {16'd0, max_age};
    endfunction

    function automatic void chain_remove(int b, int idx);
        int prv;
        int cur;
        prv = -1;
        cur = chain_head[b];
        while (cur >= 0)
        begin
            if (cur == idx)
            begin
                if (prv < 0)
                    chain_head[b] = rt_next[cur];
                else
                    rt_next[prv] = rt_next[cur];
                rt_next[cur] = -1;
                return;
            end
            prv = cur;
            cur = rt_next[cur];
        end
    endfunction

    function automatic void chain_insert(int b, int idx);
        int prv;
        int cur;
        prv = -1;
        cur = chain_head[b];
        while (cur >= 0 && rt_mask[cur] >= rt_mask[idx])
        begin
            prv = cur;
            cur = rt_next[cur];
        end
        rt_next[idx] = cur;
        if (prv < 0)
            chain_head[b] = idx;
        else
            rt_next[prv] = idx;
    endfunction

    function automatic route_reply_t route_apply(rt_pkg::func_t f, logic [31:0] addr,
                                                 logic [31:0] msk, logic [31:0] gw,
                                                 logic [7:0] cost, logic [31:0] defg,
                                                 logic [31:0] t);
        route_reply_t r;
        int b;
        int cur;
        int slot;
        b = bucket_for(addr);
        r.gate = 32'd0;
        r.status = rt_pkg::ST_NOT_FOUND;
        slot = -1;
        case (f)
            rt_pkg::FN_LOOKUP:
            begin
                r.gate = defg;
                r.status = rt_pkg::ST_DEFAULT;
                cur = chain_head[b];
                while (cur >= 0)
                begin
                    if ((addr & rt_mask[cur]) == rt_dest[cur])
                    begin
                        r.gate = rt_gate[cur];
                        r.status = rt_pkg::ST_FOUND;
                        break;
                    end
                    cur = rt_next[cur];
                end
            end
            rt_pkg::FN_ADD:
            begin
                cur = chain_head[b];
                while (cur >= 0)
                begin
                    if (rt_dest[cur] == addr && rt_mask[cur] == msk)
                    begin
                        if (cost < rt_metric[cur] || aged_out(cur, t))
                        begin
                            rt_gate[cur] = gw;
                            rt_metric[cur] = cost;
                        end
                        if (rt_gate[cur] == gw)
                            rt_stamp[cur] = t;
                        r.status = rt_pkg::ST_UPDATED;
                        return r;
                    end
                    cur = rt_next[cur];
                end
                for (int i = 0; i < NR; i++)
                    if (!rt_used[i])
                    begin
                        slot = i;
                        break;
                    end
                for (int i = 0; slot < 0 && i < NB; i++)
                begin
                    cur = chain_head[i];
                    while (cur >= 0)
                    begin
                        if (aged_out(cur, t) && rt_metric[cur] > 0)
                        begin
                            chain_remove(i, cur);
                            slot = cur;
                            evict_cnt++;
                            break;
                        end
                        cur = rt_next[cur];
                    end
                end
                if (slot < 0)
                begin
                    r.status = rt_pkg::ST_FULL;
                    full_cnt++;
                end
                else
                begin
                    rt_dest[slot] = addr;
                    rt_mask[slot] = msk;
                    rt_gate[slot] = gw;
                    rt_metric[slot] = cost;
                    rt_stamp[slot] = t;
                    rt_used[slot] = 1'b1;
                    chain_insert(b, slot);
                    r.status = rt_pkg::ST_INSTALLED;
                end
            end
            rt_pkg::FN_DEL:
            begin
                cur = chain_head[b];
                while (cur >= 0)
                begin
                    if (rt_dest[cur] == addr)
                    begin
                        chain_remove(b, cur);
                        rt_used[cur] = 1'b0;
                        r.status = rt_pkg::ST_DELETED;
                        break;
                    end
                    cur = rt_next[cur];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // sender idles in bursts
    task automatic send_route_op(rt_pkg::func_t f, logic [31:0] addr, logic [31:0] msk,
                                 logic [31:0] gw, logic [7:0] cost,
                                 logic [31:0] defg, logic [31:0] t);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            burst_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 40)) @(negedge clk);
        end
        burst_left--;
        if (!burst_on && $urandom_range(0, 1))
            repeat ($urandom_range(1, 6)) @(negedge clk);
        s_tdata <= {t, defg, cost, gw, msk, addr};
        s_tuser <= f;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        replies_due.push_back(route_apply(f, addr, msk, gw, cost, defg, t));
        sent_cnt++;
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_age_limit(logic [15:0] v);
        drain_results();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        max_age = v;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_cnt++;
            if (replies_due.size() == 0)
            begin
                $error("unexpected transaction gate_out=%h status=%0d",
                       m_tdata[31:0], m_tdata[34:32]);
                errors++;
            end
            else
            begin
                route_reply_t e;
                e = replies_due.pop_front();
                if (m_tdata[31:0] !== e.gate)
                begin
                    $error("gate_out expected %h actual %h", e.gate, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[34:32] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_tdata[34:32]);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[8])
            m_tready <= 1'b1;
        else if (stall_phase[4:0] < 5'd6)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    function automatic logic [31:0] rnd_mask();
        int n;
        n = $urandom_range(0, 32);
        return (n == 0) ? 32'd0 : (32'hFFFFFFFF << (32 - n));
    endfunction

    task automatic test_directed();
        send_route_op(rt_pkg::FN_LOOKUP, 32'h0A000001, 32'd0, 32'd0, 8'd0, 32'hDEADBEEF,
                      32'd0);
        send_route_op(rt_pkg::FN_ADD, 32'h0A000000, 32'hFF000000, 32'h0A0000FE, 8'd5,
                      32'd0, 32'd0);
        send_route_op(rt_pkg::FN_ADD, 32'h0A010000, 32'hFFFF0000, 32'h0A0100FE, 8'd9,
                      32'd0, 32'd0);
        send_route_op(rt_pkg::FN_LOOKUP, 32'h0A010203, 32'd0, 32'd0, 8'd0, 32'h1, 32'd10);
        send_route_op(rt_pkg::FN_LOOKUP, 32'h0A020203, 32'd0, 32'd0, 8'd0, 32'h1, 32'd10);
        // existing route, higher cost then lower cost
        send_route_op(rt_pkg::FN_ADD, 32'h0A000000, 32'hFF000000, 32'h11111111, 8'd7,
                      32'd0, 32'd20);
        send_route_op(rt_pkg::FN_ADD, 32'h0A000000, 32'hFF000000, 32'h11111111, 8'd2,
                      32'd0, 32'd30);
        // stale refresh
        send_route_op(rt_pkg::FN_ADD, 32'h0A000000, 32'hFF000000, 32'h22222222, 8'd255,
                      32'd0, 32'hFFFFFFFF);
        send_route_op(rt_pkg::FN_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255,
                      32'hFFFFFFFF, 32'hFFFFFFFF);
        send_route_op(rt_pkg::FN_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
                      32'hFFFFFFFF, 32'hFFFFFFFF);
        send_route_op(rt_pkg::FN_ADD, 32'h80000000, 32'd0, 32'h80808080, 8'd0, 32'd0,
                      32'd5);
        send_route_op(rt_pkg::FN_LOOKUP, 32'h80001234, 32'd0, 32'd0, 8'd0, 32'h5, 32'd5);
        send_route_op(rt_pkg::FN_DEL, 32'h0A010000, 32'd0, 32'd0, 8'd0, 32'd0, 32'd40);
        send_route_op(rt_pkg::FN_DEL, 32'h0A010000, 32'd0, 32'd0, 8'd0, 32'd0, 32'd40);
        send_route_op(rt_pkg::FN_NONE, 32'h0A000000, 32'hFF000000, 32'h1, 8'd1, 32'h3,
                      32'd40);
        send_route_op(rt_pkg::FN_LOOKUP, 32'h0A010203, 32'd0, 32'd0, 8'd0, 32'h1, 32'd50);
    endtask

    task automatic test_random(int count);
        rt_pkg::func_t f;
        logic [31:0] a;
        logic [31:0] t;
        t = $urandom;
        for (int k = 0; k < count; k++)
        begin
            t = t + $urandom_range(0, 900);
            if ($urandom_range(0, 9) == 0)
                a = $urandom;
            else
                a = dest_pool[$urandom_range(0, 15)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = rt_pkg::FN_LOOKUP;
                4, 5, 6, 7: f = rt_pkg::FN_ADD;
                8: f = rt_pkg::FN_DEL;
                default: f = ($urandom_range(0, 3) == 0) ? rt_pkg::FN_NONE : rt_pkg::FN_DEL;
            endcase
            if (f == rt_pkg::FN_LOOKUP && $urandom_range(0, 1))
                a = a | ($urandom & 32'h000000FF);
            send_route_op(f, a,
                          $urandom_range(0, 3) ? mask_pool[$urandom_range(0, 7)] : rnd_mask(),
                          $urandom_range(0, 1) ? 32'h0A0000FE : $urandom,
                          8'($urandom_range(0, 255)), $urandom, t);
        end
    endtask

    // a run of class C routes with low metrics, all at one time stamp
    task automatic test_full_table();
        logic [31:0] t;
        t = 32'h1000;
        for (int k = 0; k < 40; k++)
            send_route_op(rt_pkg::FN_ADD, {8'd192, 8'(k), 16'd0}, 32'hFFFFFF00, $urandom,
                          8'($urandom_range(0, 3)), 32'd0, t);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = rt_pkg::FN_LOOKUP;
        cfg_we = 1'b0;
        cfg_data = '0;
        m_tready = 1'b0;
        stall_phase = 0;
        errors = 0;
        sent_cnt = 0;
        rx_cnt = 0;
        full_cnt = 0;
        evict_cnt = 0;
        burst_left = 0;
        burst_on = 1'b1;
        max_age = rt_pkg::AGE_RESET;
        for (int i = 0; i < NR; i++)
        begin
            rt_used[i] = 1'b0;
            rt_next[i] = -1;
            rt_metric[i] = '0;
        end
        for (int i = 0; i < NB; i++)
            chain_head[i] = -1;
        for (int i = 0; i < 16; i++)
            dest_pool[i] = {8'($urandom_range(0, 255)), 8'($urandom), 16'd0} &
                           ((i < 8) ? 32'hFFFF0000 : 32'hFFFFFF00);
        for (int i = 0; i < 8; i++)
            mask_pool[i] = (i < 4) ? 32'hFFFF0000 : 32'hFFFFFF00;
        mask_pool[0] = 32'hFF000000;
        mask_pool[7] = 32'hFFFFFFFF;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        drain_results();
        set_age_limit(16'd0);
        test_random(120);
        set_age_limit(16'hFFFF);
        test_random(120);
        drain_results();
        set_age_limit(16'd300);
        test_random(140);
        test_full_table();
        set_age_limit(rt_pkg::AGE_RESET);
        test_random(120);
        drain_results();

        $display("sent %0d operations, checked %0d replies", sent_cnt, rx_cnt);
        $display("age limits 0..65535, %0d evictions, %0d table-full replies",
                 evict_cnt, full_cnt);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
